// ===== design/sat_pkg.sv =====
// Package for the sorted address table: widths, operation and status codes,
// and the entry, request, response and memory port layouts. No dependencies.
package sat_pkg;

    localparam int unsigned ENTRIES    = 1024;
    localparam int unsigned IDX_W      = $clog2(ENTRIES);
    localparam int unsigned CNT_W      = IDX_W + 1;
    localparam int unsigned ADDR_W     = 64;
    localparam int unsigned SIZE_W     = 48;
    localparam int unsigned SLOT_W     = 10;

    localparam logic [1:0] OP_LOOKUP   = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;
    localparam logic [1:0] OP_RELOCATE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic              direct;
    } entry_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] entry_address;
        logic [SIZE_W-1:0] block_size;
        logic              direct_flag;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SIZE_W-1:0] found_size;
        logic              found_direct;
        logic [SLOT_W-1:0] slot;
    } rsp_t;

    // Memory port bundle between sequencer and entry store
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_data;
    } mem_ctl_t;

endpackage

// ===== design/sat_if.sv =====
// Valid/ready channel interface carrying one word of type T.
// No dependencies; the payload type T is a parameter.
interface sat_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/sat_mem.sv =====
// Entry store: one synchronous RAM of entry words, one read and one write port.
// Depends on sat_pkg.
module sat_mem
(
    input  logic              clk,
    input  sat_pkg::mem_ctl_t ctl,
    output sat_pkg::entry_t   rd_data
);

    sat_pkg::entry_t mem [sat_pkg::ENTRIES];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_idx] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data <= mem[ctl.rd_idx];
        end
    end

endmodule

// ===== design/sat_seq.sv =====
// Operation sequencer: binary search, shift-up insert and in-place updates
// over the entry store. Depends on sat_pkg and sat_if.
module sat_seq
(
    input  logic              clk,
    input  logic              rst_n,
    sat_if.sink               req,
    sat_if.source             rsp,
    output sat_pkg::mem_ctl_t ctl,
    input  sat_pkg::entry_t   rd_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;
    localparam logic [3:0] S_SWAIT  = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_SHRD   = 4'd4;
    localparam logic [3:0] S_SHWR   = 4'd5;
    localparam logic [3:0] S_PLACE  = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;
    localparam logic [3:0] S_T1     = 4'd8;

    localparam int unsigned CW = sat_pkg::CNT_W;
    localparam int unsigned IW = sat_pkg::IDX_W;
    localparam int unsigned ADDR_W_L = sat_pkg::ADDR_W;

    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] sh_reg, sh_next;
    logic          hit_reg, hit_next;
    logic          phase_reg, phase_next;   // relocate: 0 source search, 1 target
    logic [IW-1:0] src_reg, src_next;
    sat_pkg::entry_t src_e_reg, src_e_next;
    sat_pkg::entry_t hit_e_reg, hit_e_next;
    sat_pkg::req_t   r_reg, r_next;
    sat_pkg::rsp_t   o_reg, o_next;
    logic            ov_reg, ov_next;

    logic [ADDR_W_L-1:0] key;
    logic [CW-1:0] mid_c;

    assign req.ready = (state_reg == S_IDLE) && !(ov_reg && !rsp.ready);
    assign rsp.valid = ov_reg;
    assign rsp.data  = o_reg;

    always_comb
    begin
        if (r_reg.operation == sat_pkg::OP_LOOKUP || r_reg.operation == sat_pkg::OP_ADD
            || phase_reg)
        begin
            key = r_reg.address;
        end
        else
        begin
            key = r_reg.entry_address;
        end
    end

    assign mid_c = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        sh_next    = sh_reg;
        hit_next   = hit_reg;
        phase_next = phase_reg;
        src_next   = src_reg;
        src_e_next = src_e_reg;
        hit_e_next = hit_e_reg;
        r_next     = r_reg;
        o_next     = o_reg;
        ov_next    = ov_reg;
        ctl        = '0;

        if (ov_reg && rsp.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    r_next     = req.data;
                    phase_next = 1'b0;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    hit_next   = 1'b0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_c;
                    ctl.rd_en  = 1'b1;
                    ctl.rd_idx = mid_c[IW-1:0];
                    state_next = S_SWAIT;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_SWAIT:
            begin
                if (rd_data.addr == key)
                begin
                    hit_next   = 1'b1;
                    hit_e_next = rd_data;
                    lo_next    = mid_reg;
                    state_next = S_DECIDE;
                end
                else if (rd_data.addr > key)
                begin
                    hi_next    = mid_reg;
                    state_next = S_SRCH;
                end
                else
                begin
                    lo_next    = mid_reg + 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_DECIDE:
            begin
                // lo_reg holds the match or the insertion point
                o_next     = '0;
                o_next.status = sat_pkg::ST_MISS;
                state_next = S_OUT;
                unique case (r_reg.operation)
                    sat_pkg::OP_LOOKUP:
                    begin
                        if (hit_reg && hit_e_reg.size != '0)
                        begin
                            o_next.status       = sat_pkg::ST_OK;
                            o_next.found_size   = hit_e_reg.size;
                            o_next.found_direct = hit_e_reg.direct;
                            o_next.slot         = lo_reg[sat_pkg::SLOT_W-1:0];
                        end
                    end
                    sat_pkg::OP_REMOVE:
                    begin
                        if (hit_reg && hit_e_reg.size != '0)
                        begin
                            ctl.wr_en   = 1'b1;
                            ctl.wr_idx  = lo_reg[IW-1:0];
                            ctl.wr_data = '{addr: hit_e_reg.addr, size: '0, direct: 1'b0};
                            o_next.status = sat_pkg::ST_OK;
                            o_next.slot   = lo_reg[sat_pkg::SLOT_W-1:0];
                        end
                    end
                    sat_pkg::OP_RELOCATE:
                    begin
                        if (!phase_reg)
                        begin
                            if (hit_reg && hit_e_reg.size != '0)
                            begin
                                src_next   = lo_reg[IW-1:0];
                                src_e_next = hit_e_reg;
                                phase_next = 1'b1;
                                lo_next    = '0;
                                hi_next    = count_reg;
                                hit_next   = 1'b0;
                                state_next = S_SRCH;
                            end
                        end
                        else if (!hit_reg && count_reg >= CW'(sat_pkg::ENTRIES))
                        begin
                            o_next.status = sat_pkg::ST_FULL;
                        end
                        else
                        begin
                            // clear the source, then place at the target
                            ctl.wr_en   = 1'b1;
                            ctl.wr_idx  = src_reg;
                            ctl.wr_data = '{addr: src_e_reg.addr, size: '0, direct: 1'b0};
                            r_next.block_size  = src_e_reg.size;
                            r_next.direct_flag = src_e_reg.direct;
                            state_next = S_T1;
                        end
                    end
                    default:
                    begin
                        if (!hit_reg && count_reg >= CW'(sat_pkg::ENTRIES))
                        begin
                            o_next.status = sat_pkg::ST_FULL;
                        end
                        else
                        begin
                            state_next = S_T1;
                        end
                    end
                endcase
            end
            S_T1:
            begin
                if (hit_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    sh_next    = count_reg;
                    state_next = S_SHRD;
                end
            end
            S_SHRD:
            begin
                if (sh_reg > lo_reg)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_idx = IW'(sh_reg - 1'b1);
                    state_next = S_SHWR;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = S_PLACE;
                end
            end
            S_SHWR:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_idx  = sh_reg[IW-1:0];
                ctl.wr_data = rd_data;
                sh_next     = sh_reg - 1'b1;
                state_next  = S_SHRD;
            end
            S_PLACE:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_idx  = lo_reg[IW-1:0];
                ctl.wr_data = '{addr: r_reg.address, size: r_reg.block_size,
                                direct: r_reg.direct_flag};
                o_next.status       = sat_pkg::ST_OK;
                o_next.found_size   = r_reg.block_size;
                o_next.found_direct = r_reg.direct_flag;
                o_next.slot         = lo_reg[sat_pkg::SLOT_W-1:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        sh_reg    <= sh_next;
        hit_reg   <= hit_next;
        phase_reg <= phase_next;
        src_reg   <= src_next;
        src_e_reg <= src_e_next;
        hit_e_reg <= hit_e_next;
        r_reg     <= r_next;
        o_reg     <= o_next;
    end

endmodule

// ===== design/sorted_address_table.sv =====
// Sorted address table: request channel in, one result word out per request.
//
// Usage: present a request word on req (operation, address, entry_address,
// block_size, direct_flag); exactly one result word (status, found_size,
// found_direct, slot) follows on rsp for each. Words move when valid and
// ready are both high.
//
// Search: each probe of the binary search issues a RAM read (S_SRCH) and
// then compares the read word (S_SWAIT). Lookup and remove finish after one
// search; relocate runs two when its source is found. An add or relocate
// that inserts a new address also shifts every later entry up by one,
// reading (S_SHRD) and then writing (S_SHWR) each moved entry in turn
// through the single read port of the entry RAM.
// Requests are handled one at a time; the next one is taken only once the
// previous result word leaves, which may be in the same cycle.
// Reset empties the table at once (the entry count goes to zero); RAM
// contents are not cleared. A stalled receiver holds the result register
// and the request side stays not ready until it drains.
module sorted_address_table
(
    input logic   clk,
    input logic   rst_n,
    sat_if.sink   req,
    sat_if.source rsp
);

    sat_pkg::mem_ctl_t ctl;
    sat_pkg::entry_t   rd_data;

    sat_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .ctl     (ctl),
        .rd_data (rd_data)
    );

    sat_mem u_mem
    (
        .clk     (clk),
        .ctl     (ctl),
        .rd_data (rd_data)
    );

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.status == sat_pkg::ST_FULL |->
            rsp.data.found_size == '0 && rsp.data.slot == '0)
        else $error("full status carries payload");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.wr_en && ctl.rd_en && ctl.wr_idx == ctl.rd_idx))
        else $error("read and write of one entry in one cycle");

    a_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.data.status != 2'd3)
        else $error("undefined status code");

endmodule
